>>> rtl/core/quaternion_arithmetic_unit_core_assert.svh
// Assertion macros shared by the quaternion unit RTL.
`ifndef QUATERNION_ARITHMETIC_UNIT_CORE_ASSERT_SVH
`define QUATERNION_ARITHMETIC_UNIT_CORE_ASSERT_SVH
`ifndef SYNTHESIS
// Check a property outside reset.
`define QAU_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("quaternion unit check failed");
// Check a property at every edge, reset included.
`define QAU_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("quaternion unit reset check failed");
`else
`define QAU_ASSERT(lbl, clk, rst_n, prop)
`define QAU_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

>>> rtl/core/qau_pkg.sv
// Types, constants and helpers shared by the quaternion unit.
package qau_pkg;

  localparam int DATA_W        = 32;
  localparam int FRAC_BITS_DEF = 16;
  localparam int PROD_W        = 2 * DATA_W;
  localparam int ACC_W         = PROD_W + 2;
  localparam int SUM_W         = PROD_W + 1;
  localparam int SQRT_STEPS    = DATA_W + 1;
  localparam int RAD_W         = 2 * SQRT_STEPS;
  localparam int REM_W         = SQRT_STEPS + 2;
  localparam int DREM_W        = DATA_W + 2;

  localparam logic [2:0] OP_MUL   = 3'd0;
  localparam logic [2:0] OP_ADD   = 3'd1;
  localparam logic [2:0] OP_SCALE = 3'd2;
  localparam logic [2:0] OP_ROT   = 3'd3;
  localparam logic [2:0] OP_NORM  = 3'd4;

  localparam logic signed [ACC_W-1:0] Q_MAX = ACC_W'(64'sd2147483647);
  localparam logic signed [ACC_W-1:0] Q_MIN = -ACC_W'(64'sd2147483648);

  typedef logic [3:0][DATA_W-1:0] quat_t;

  typedef struct packed {
    logic [2:0]              op;
    quat_t                   r;
    logic                    sat;
    logic [3:0][DATA_W-1:0]  mag;
    logic [3:0]              neg;
    logic                    zero;
  } payload_t;

  typedef struct packed {
    logic [RAD_W-1:0]      rad;
    logic [REM_W-1:0]      rem;
    logic [SQRT_STEPS-1:0] root;
  } sqrt_t;

  typedef struct packed {
    logic [SQRT_STEPS-1:0]   m;
    logic [3:0][DREM_W-1:0]  rem;
    logic [3:0][DATA_W-1:0]  quo;
  } div_t;

  // Clamp to the signed 32-bit range; the top bit flags a clamp.
  function automatic logic [DATA_W:0] sat_q(input logic signed [ACC_W-1:0] v);
    logic [DATA_W:0] res;
    if (v > Q_MAX) begin
      res = {1'b1, Q_MAX[DATA_W-1:0]};
    end else if (v < Q_MIN) begin
      res = {1'b1, Q_MIN[DATA_W-1:0]};
    end else begin
      res = {1'b0, v[DATA_W-1:0]};
    end
    return res;
  endfunction

endpackage

>>> rtl/core/qau_front.sv
// Multiplier front end: scale, add, Hamilton product and sum of squares.
module qau_front #(
  parameter int FRAC_BITS = qau_pkg::FRAC_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     en,
  input  logic                     in_valid,
  input  logic [2:0]               in_op,
  input  qau_pkg::quat_t           in_p,
  input  qau_pkg::quat_t           in_q,
  input  logic [qau_pkg::DATA_W-1:0] in_s,
  output logic                     out_valid,
  output qau_pkg::payload_t        out_pay,
  output logic [qau_pkg::SUM_W-1:0] out_sum
);
  import qau_pkg::*;

  logic v1_r, v2_r, v3_r, v4_r, v5_r;
  logic [2:0] op1_r, op2_r, op3_r, op4_r;
  quat_t p1_r, p2_r, p3_r, p4_r, q1_r, q2_r;
  quat_t sc2_r, sc3_r, sc4_r, ad2_r, ad3_r, ad4_r;
  logic [3:0] scf2_r, scf3_r, scf4_r, adf2_r, adf3_r, adf4_r;
  logic signed [PROD_W-1:0] sp1_r [4];
  logic signed [PROD_W-1:0] sp_nxt [4];
  logic signed [PROD_W-1:0] mp3_r [4][4];
  logic signed [PROD_W-1:0] mp_nxt [4][4];
  logic signed [ACC_W-1:0] h4_r [4];
  logic signed [ACC_W-1:0] h_nxt [4];
  logic signed [ACC_W-1:0] sq_sum;
  logic [SUM_W-1:0] sum4_r, sum5_r;
  logic [DATA_W:0] scs [4];
  logic [DATA_W:0] ads [4];
  logic [DATA_W:0] hs [4];
  quat_t b;
  payload_t pay_nxt, pay5_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      {v1_r, v2_r, v3_r, v4_r, v5_r} <= '0;
    end else if (en) begin
      {v1_r, v2_r, v3_r, v4_r, v5_r} <= {in_valid, v1_r, v2_r, v3_r, v4_r};
    end
  end

  // Stage 1: scale products, p for scale and q.xyz for rotate.
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      sp_nxt[i] = $signed(in_op == OP_SCALE ? in_p[i] : in_q[i]) * $signed(in_s);
    end
  end

  // Stage 2: floor and clamp the scaled values, clamp the sums.
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      scs[i] = sat_q($signed(ACC_W'(sp1_r[i])) >>> FRAC_BITS);
      ads[i] = sat_q($signed(ACC_W'($signed(p1_r[i]))) + $signed(ACC_W'($signed(q1_r[i]))));
    end
  end

  // Stage 3: sixteen products against q, the pure vector or p itself.
  always_comb begin
    unique case (op2_r)
      OP_ROT:  b = {sc2_r[3], sc2_r[2], sc2_r[1], {DATA_W{1'b0}}};
      OP_NORM: b = p2_r;
      default: b = q2_r;
    endcase
    for (int k = 0; k < 4; k++) begin
      for (int j = 0; j < 4; j++) begin
        mp_nxt[k][j] = $signed(p2_r[k]) * $signed(b[j]);
      end
    end
  end

  // Stage 4: Hamilton row sums and the sum of squares.
  always_comb begin
    h_nxt[0] = ACC_W'(mp3_r[0][0]) - ACC_W'(mp3_r[1][1]) - ACC_W'(mp3_r[2][2])
             - ACC_W'(mp3_r[3][3]);
    h_nxt[1] = ACC_W'(mp3_r[0][1]) + ACC_W'(mp3_r[1][0]) + ACC_W'(mp3_r[2][3])
             - ACC_W'(mp3_r[3][2]);
    h_nxt[2] = ACC_W'(mp3_r[0][2]) - ACC_W'(mp3_r[1][3]) + ACC_W'(mp3_r[2][0])
             + ACC_W'(mp3_r[3][1]);
    h_nxt[3] = ACC_W'(mp3_r[0][3]) + ACC_W'(mp3_r[1][2]) - ACC_W'(mp3_r[2][1])
             + ACC_W'(mp3_r[3][0]);
    sq_sum   = ACC_W'(mp3_r[0][0]) + ACC_W'(mp3_r[1][1]) + ACC_W'(mp3_r[2][2])
             + ACC_W'(mp3_r[3][3]);
  end

  // Stage 5: floor, clamp and pick the result of the opcode.
  always_comb begin
    pay_nxt = '0;
    pay_nxt.op = op4_r;
    for (int i = 0; i < 4; i++) begin
      hs[i] = sat_q(h4_r[i] >>> FRAC_BITS);
      pay_nxt.neg[i] = p4_r[i][DATA_W-1];
      pay_nxt.mag[i] = p4_r[i][DATA_W-1] ? DATA_W'(0) - p4_r[i] : p4_r[i];
    end
    pay_nxt.zero = (sum4_r == '0);
    unique case (op4_r)
      OP_MUL: begin
        pay_nxt.r   = {hs[3][DATA_W-1:0], hs[2][DATA_W-1:0], hs[1][DATA_W-1:0],
                       hs[0][DATA_W-1:0]};
        pay_nxt.sat = hs[0][DATA_W] | hs[1][DATA_W] | hs[2][DATA_W] | hs[3][DATA_W];
      end
      OP_ROT: begin
        pay_nxt.r   = {hs[3][DATA_W-1:0], hs[2][DATA_W-1:0], hs[1][DATA_W-1:0],
                       hs[0][DATA_W-1:0]};
        pay_nxt.sat = hs[0][DATA_W] | hs[1][DATA_W] | hs[2][DATA_W] | hs[3][DATA_W]
                    | (|scf4_r[3:1]);
      end
      OP_ADD: begin
        pay_nxt.r   = ad4_r;
        pay_nxt.sat = |adf4_r;
      end
      OP_SCALE: begin
        pay_nxt.r   = sc4_r;
        pay_nxt.sat = |scf4_r;
      end
      default: begin
        pay_nxt.r   = '0;
        pay_nxt.sat = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      op1_r <= in_op;
      p1_r  <= in_p;
      q1_r  <= in_q;
      for (int i = 0; i < 4; i++) begin
        sp1_r[i]  <= sp_nxt[i];
        sc2_r[i]  <= scs[i][DATA_W-1:0];
        scf2_r[i] <= scs[i][DATA_W];
        ad2_r[i]  <= ads[i][DATA_W-1:0];
        adf2_r[i] <= ads[i][DATA_W];
        h4_r[i]   <= h_nxt[i];
        for (int j = 0; j < 4; j++) begin
          mp3_r[i][j] <= mp_nxt[i][j];
        end
      end
      op2_r  <= op1_r;
      p2_r   <= p1_r;
      q2_r   <= q1_r;
      op3_r  <= op2_r;
      p3_r   <= p2_r;
      sc3_r  <= sc2_r;
      scf3_r <= scf2_r;
      ad3_r  <= ad2_r;
      adf3_r <= adf2_r;
      op4_r  <= op3_r;
      p4_r   <= p3_r;
      sc4_r  <= sc3_r;
      scf4_r <= scf3_r;
      ad4_r  <= ad3_r;
      adf4_r <= adf3_r;
      sum4_r <= sq_sum[SUM_W-1:0];
      pay5_r <= pay_nxt;
      sum5_r <= sum4_r;
    end
  end

  assign out_valid = v5_r;
  assign out_pay   = pay5_r;
  assign out_sum   = sum5_r;

endmodule

>>> rtl/core/qau_sqrt_cell.sv
// One digit cell of the pipelined integer square root.
module qau_sqrt_cell (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_valid,
  input  qau_pkg::payload_t in_pay,
  input  qau_pkg::sqrt_t    in_sq,
  output logic              out_valid,
  output qau_pkg::payload_t out_pay,
  output qau_pkg::sqrt_t    out_sq
);
  import qau_pkg::*;

  logic valid_r;
  payload_t pay_r;
  sqrt_t sq_r, sq_nxt;
  logic [REM_W-1:0] rem2, trial;
  logic ge;

  // Bring down two radicand bits and try to set the next root bit.
  always_comb begin
    rem2  = {in_sq.rem[REM_W-3:0], in_sq.rad[RAD_W-1:RAD_W-2]};
    trial = {in_sq.root, 2'b01};
    ge    = (rem2 >= trial);
    sq_nxt.rad  = {in_sq.rad[RAD_W-3:0], 2'b00};
    sq_nxt.rem  = ge ? rem2 - trial : rem2;
    sq_nxt.root = {in_sq.root[SQRT_STEPS-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pay_r <= in_pay;
      sq_r  <= sq_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_pay   = pay_r;
  assign out_sq    = sq_r;

endmodule

>>> rtl/core/qau_div_cell.sv
// One quotient-bit cell of the four-lane pipelined divider.
module qau_div_cell (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_valid,
  input  qau_pkg::payload_t in_pay,
  input  qau_pkg::div_t     in_dv,
  output logic              out_valid,
  output qau_pkg::payload_t out_pay,
  output qau_pkg::div_t     out_dv
);
  import qau_pkg::*;

  logic valid_r;
  payload_t pay_r;
  div_t dv_r, dv_nxt;
  logic [DREM_W-1:0] dvs;
  logic [DREM_W-1:0] d [4];
  logic [3:0] ge;

  // Compare, subtract on success, shift the remainder for the next bit.
  always_comb begin
    dvs = DREM_W'(in_dv.m);
    dv_nxt.m = in_dv.m;
    for (int i = 0; i < 4; i++) begin
      ge[i] = (in_dv.rem[i] >= dvs);
      d[i]  = ge[i] ? in_dv.rem[i] - dvs : in_dv.rem[i];
      dv_nxt.rem[i] = {d[i][DREM_W-2:0], 1'b0};
      dv_nxt.quo[i] = {in_dv.quo[i][DATA_W-2:0], ge[i]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pay_r <= in_pay;
      dv_r  <= dv_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_pay   = pay_r;
  assign out_dv    = dv_r;

endmodule

>>> rtl/core/quaternion_arithmetic_unit_core.sv
// Top level of the Q16.16 quaternion arithmetic unit.
// Every opcode takes the same path through the front stages, root cells and divider
// cells to the output register.
// Throughput: one transaction per cycle while in_stall is low; 5 front stages, 33 root cells and
// FRAC_BITS + 1 divider cells all advance together whenever the pipe is enabled.
// Reset: rst_n is synchronous, active low; it empties the pipe and the output.
`include "quaternion_arithmetic_unit_core_assert.svh"
module quaternion_arithmetic_unit_core #(
  parameter int FRAC_BITS = qau_pkg::FRAC_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [2:0]                  in_op,
  input  logic signed [qau_pkg::DATA_W-1:0] in_p_w,
  input  logic signed [qau_pkg::DATA_W-1:0] in_p_x,
  input  logic signed [qau_pkg::DATA_W-1:0] in_p_y,
  input  logic signed [qau_pkg::DATA_W-1:0] in_p_z,
  input  logic signed [qau_pkg::DATA_W-1:0] in_q_w,
  input  logic signed [qau_pkg::DATA_W-1:0] in_q_x,
  input  logic signed [qau_pkg::DATA_W-1:0] in_q_y,
  input  logic signed [qau_pkg::DATA_W-1:0] in_q_z,
  input  logic signed [qau_pkg::DATA_W-1:0] in_factor,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic signed [qau_pkg::DATA_W-1:0] out_r_w,
  output logic signed [qau_pkg::DATA_W-1:0] out_r_x,
  output logic signed [qau_pkg::DATA_W-1:0] out_r_y,
  output logic signed [qau_pkg::DATA_W-1:0] out_r_z,
  output logic                        out_saturated
);
  import qau_pkg::*;

  localparam int DIV_STEPS = FRAC_BITS + 1;

  // The whole pipe moves as one; it holds only when the output skid is full.
  logic en;

  // Root chain: one result bit per cell, two radicand bits per cell.
  logic     sv [SQRT_STEPS+1];
  payload_t spay [SQRT_STEPS+1];
  sqrt_t    ssq [SQRT_STEPS+1];

  // Divider chain: one quotient bit per cell, four lanes side by side.
  logic     dvv [DIV_STEPS+1];
  payload_t dpay [DIV_STEPS+1];
  div_t     ddv [DIV_STEPS+1];

  logic [SUM_W-1:0] front_sum;

  // Final select and the two-entry output skid.
  logic       fin_valid_r;
  logic [2:0] fin_op_r;
  quat_t      fin_r, fin_nxt;
  logic       fin_sat_r, fin_sat_nxt;
  quat_t      out_r, spare_r;
  logic       out_sat_r, spare_sat_r;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push, pop;

  qau_front #(
    .FRAC_BITS(FRAC_BITS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (in_valid),
    .in_op    (in_op),
    .in_p     ({in_p_z, in_p_y, in_p_x, in_p_w}),
    .in_q     ({in_q_z, in_q_y, in_q_x, in_q_w}),
    .in_s     (in_factor),
    .out_valid(sv[0]),
    .out_pay  (spay[0]),
    .out_sum  (front_sum)
  );

  // Seed the root chain with the exact sum of squares, zero extended to even width.
  assign ssq[0].rad  = RAD_W'(front_sum);
  assign ssq[0].rem  = '0;
  assign ssq[0].root = '0;

  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
    qau_sqrt_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (en),
      .in_valid (sv[k]),
      .in_pay   (spay[k]),
      .in_sq    (ssq[k]),
      .out_valid(sv[k+1]),
      .out_pay  (spay[k+1]),
      .out_sq   (ssq[k+1])
    );
  end

  // Seed the divider: divisor is the root, each lane starts from |p_i|.
  // Since |p_i| never exceeds the root, the quotient fits FRAC_BITS + 1 bits.
  assign dvv[0]   = sv[SQRT_STEPS];
  assign dpay[0]  = spay[SQRT_STEPS];
  assign ddv[0].m = ssq[SQRT_STEPS].root;
  for (genvar i = 0; i < 4; i++) begin : g_seed
    assign ddv[0].rem[i] = DREM_W'(spay[SQRT_STEPS].mag[i]);
    assign ddv[0].quo[i] = '0;
  end

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
    qau_div_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (en),
      .in_valid (dvv[k]),
      .in_pay   (dpay[k]),
      .in_dv    (ddv[k]),
      .out_valid(dvv[k+1]),
      .out_pay  (dpay[k+1]),
      .out_dv   (ddv[k+1])
    );
  end

  // Normalize takes the signed quotients; a zero magnitude gives the unit
  // quaternion. Every other opcode passes its front-end result through.
  always_comb begin
    fin_nxt     = dpay[DIV_STEPS].r;
    fin_sat_nxt = dpay[DIV_STEPS].sat;
    if (dpay[DIV_STEPS].op == OP_NORM) begin
      fin_sat_nxt = 1'b0;
      if (dpay[DIV_STEPS].zero) begin
        fin_nxt    = '0;
        fin_nxt[0] = DATA_W'(1) << FRAC_BITS;
      end else begin
        for (int i = 0; i < 4; i++) begin
          fin_nxt[i] = dpay[DIV_STEPS].neg[i] ? DATA_W'(0) - ddv[DIV_STEPS].quo[i]
                                              : ddv[DIV_STEPS].quo[i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fin_valid_r <= 1'b0;
    end else if (en) begin
      fin_valid_r <= dvv[DIV_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fin_r     <= fin_nxt;
      fin_sat_r <= fin_sat_nxt;
      fin_op_r  <= dpay[DIV_STEPS].op;
    end
  end

  // Output skid: the output register plus one spare entry, so the pipe keeps
  // taking transactions after the sink starts to stall, until the spare is full.
  assign en   = (cnt_r != 2'd2);
  assign push = fin_valid_r && en;
  assign pop  = (cnt_r != 2'd0) && !out_stall;

  always_comb begin
    cnt_nxt = cnt_r;
    priority if (push && !pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 2'd1;
    end else begin
      cnt_nxt = cnt_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    priority if (pop && cnt_r == 2'd2) begin
      out_r     <= spare_r;
      out_sat_r <= spare_sat_r;
    end else if (push && (pop || cnt_r == 2'd0)) begin
      out_r     <= fin_r;
      out_sat_r <= fin_sat_r;
    end else if (push) begin
      spare_r     <= fin_r;
      spare_sat_r <= fin_sat_r;
    end else begin
      out_r     <= out_r;
      out_sat_r <= out_sat_r;
    end
  end

  assign in_stall      = !en;
  assign out_valid     = (cnt_r != 2'd0);
  assign out_r_w       = out_r[0];
  assign out_r_x       = out_r[1];
  assign out_r_y       = out_r[2];
  assign out_r_z       = out_r[3];
  assign out_saturated = out_sat_r;

  // A full skid drains by at most one entry per cycle.
  `QAU_ASSERT(a_skid_drain, clk, rst_n, (cnt_r == 2'd2) |=> (cnt_r != 2'd0))
  // Normalize results are bounded by one and never clamp.
  `QAU_ASSERT(a_norm_nosat, clk, rst_n, (fin_valid_r && fin_op_r == OP_NORM) |-> !fin_sat_r)
  // Unused opcodes give an all-zero result without the flag.
  `QAU_ASSERT(a_unused_zero, clk, rst_n, (fin_valid_r && fin_op_r > OP_NORM) |-> (fin_r == '0 && !fin_sat_r))
  // Reset leaves the output empty.
  `QAU_ASSERT_ALWAYS(a_reset_empty, clk, $past(!rst_n) |-> (cnt_r == 2'd0))

endmodule

>>> dv/quaternion_arithmetic_unit_core_checker.sv
// Scoreboard for the quaternion unit: predicts each result and compares it.
module quaternion_arithmetic_unit_core_checker (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  input  logic                              in_stall,
  input  logic [2:0]                        in_op,
  input  logic signed [qau_pkg::DATA_W-1:0] in_p_w,
  input  logic signed [qau_pkg::DATA_W-1:0] in_p_x,
  input  logic signed [qau_pkg::DATA_W-1:0] in_p_y,
  input  logic signed [qau_pkg::DATA_W-1:0] in_p_z,
  input  logic signed [qau_pkg::DATA_W-1:0] in_q_w,
  input  logic signed [qau_pkg::DATA_W-1:0] in_q_x,
  input  logic signed [qau_pkg::DATA_W-1:0] in_q_y,
  input  logic signed [qau_pkg::DATA_W-1:0] in_q_z,
  input  logic signed [qau_pkg::DATA_W-1:0] in_factor,
  input  logic                              out_valid,
  input  logic                              out_stall,
  input  logic signed [qau_pkg::DATA_W-1:0] out_r_w,
  input  logic signed [qau_pkg::DATA_W-1:0] out_r_x,
  input  logic signed [qau_pkg::DATA_W-1:0] out_r_y,
  input  logic signed [qau_pkg::DATA_W-1:0] out_r_z,
  input  logic                              out_saturated,
  output int                                fail_count,
  output int                                pending_count
);
  import qau_pkg::*;

  localparam int FB = FRAC_BITS_DEF;

  typedef struct {
    logic signed [31:0] c [4];
    logic               sat;
  } quat_result_t;

  quat_result_t expected_results[$];

  function automatic logic signed [31:0] clamp32(input logic signed [67:0] v,
                                                 inout logic flag);
    if (v > 68'sd2147483647) begin
      flag = 1'b1;
      return 32'sh7fffffff;
    end else if (v < -68'sd2147483648) begin
      flag = 1'b1;
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

  // Exact four-term sums with arithmetic shift give the floored value.
  function automatic void hamilton_product(input logic signed [31:0] a [4],
                                           input logic signed [31:0] b [4],
                                           inout quat_result_t res);
    logic signed [67:0] t0, t1, t2, t3;
    t0 = 68'(a[0]) * b[0] - 68'(a[1]) * b[1] - 68'(a[2]) * b[2] - 68'(a[3]) * b[3];
    t1 = 68'(a[0]) * b[1] + 68'(a[1]) * b[0] + 68'(a[2]) * b[3] - 68'(a[3]) * b[2];
    t2 = 68'(a[0]) * b[2] - 68'(a[1]) * b[3] + 68'(a[2]) * b[0] + 68'(a[3]) * b[1];
    t3 = 68'(a[0]) * b[3] + 68'(a[1]) * b[2] - 68'(a[2]) * b[1] + 68'(a[3]) * b[0];
    res.c[0] = clamp32(t0 >>> FB, res.sat);
    res.c[1] = clamp32(t1 >>> FB, res.sat);
    res.c[2] = clamp32(t2 >>> FB, res.sat);
    res.c[3] = clamp32(t3 >>> FB, res.sat);
  endfunction

  function automatic logic [32:0] root_floor(input logic [65:0] v);
    logic [65:0] r, b;
    r = 0;
    b = 66'd1 << 64;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r[32:0];
  endfunction

  function automatic quat_result_t predict_quat(input logic [2:0] op,
                                                input logic signed [31:0] p [4],
                                                input logic signed [31:0] q [4],
                                                input logic signed [31:0] s);
    quat_result_t res;
    logic signed [31:0] v [4];
    logic [65:0] sumsq, mag;
    logic [32:0] m;
    res.sat = 1'b0;
    for (int i = 0; i < 4; i++) res.c[i] = '0;
    case (op)
      OP_MUL: hamilton_product(p, q, res);
      OP_ADD:
        for (int i = 0; i < 4; i++) res.c[i] = clamp32(68'(p[i]) + q[i], res.sat);
      OP_SCALE:
        for (int i = 0; i < 4; i++) res.c[i] = clamp32((68'(p[i]) * s) >>> FB, res.sat);
      OP_ROT: begin
        v[0] = '0;
        for (int i = 1; i < 4; i++) v[i] = clamp32((68'(q[i]) * s) >>> FB, res.sat);
        hamilton_product(p, v, res);
      end
      OP_NORM: begin
        sumsq = 0;
        for (int i = 0; i < 4; i++) sumsq = sumsq + 66'(68'(p[i]) * p[i]);
        if (sumsq == 0) begin
          res.c[0] = 32'sd1 <<< FB;
        end else begin
          m = root_floor(sumsq);
          for (int i = 0; i < 4; i++) begin
            mag = p[i] < 0 ? 66'(-68'(p[i])) : 66'(p[i]);
            mag = (mag << FB) / m;
            res.c[i] = p[i] < 0 ? -mag[31:0] : mag[31:0];
          end
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  assign pending_count = expected_results.size();

  always @(posedge clk) begin
    logic signed [31:0] p [4], q [4], got [4];
    quat_result_t want;
    if (!rst_n) begin
      fail_count <= 0;
    end else begin
      if (in_valid && !in_stall) begin
        p = '{in_p_w, in_p_x, in_p_y, in_p_z};
        q = '{in_q_w, in_q_x, in_q_y, in_q_z};
        expected_results.push_back(predict_quat(in_op, p, q, in_factor));
      end
      if (out_valid && !out_stall) begin
        got = '{out_r_w, out_r_x, out_r_y, out_r_z};
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected transaction r=%h %h %h %h", $time,
                   got[0], got[1], got[2], got[3]);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_results.pop_front();
          if (want.c != got || want.sat != out_saturated) begin
            $display("%0t: expected %h %h %h %h sat %b, actual %h %h %h %h sat %b",
                     $time, want.c[0], want.c[1], want.c[2], want.c[3], want.sat,
                     got[0], got[1], got[2], got[3], out_saturated);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end
endmodule

>>> dv/quaternion_arithmetic_unit_core_test.sv
// Stimulus and verdict for the quaternion unit test.
module quaternion_arithmetic_unit_core_test;
  import qau_pkg::*;

  localparam int NUM_RANDOM = 1450;
  localparam int CYCLE_LIMIT = 400000;

  logic clk, rst_n;
  logic in_valid, in_stall, out_valid, out_stall, out_saturated;
  logic [2:0] in_op;
  logic signed [31:0] in_p_w, in_p_x, in_p_y, in_p_z;
  logic signed [31:0] in_q_w, in_q_x, in_q_y, in_q_z, in_factor;
  logic signed [31:0] out_r_w, out_r_x, out_r_y, out_r_z;
  int fail_count, pending_count, cycle_count;
  bit steady_phase;

  quaternion_arithmetic_unit_core uut (.*);
  quaternion_arithmetic_unit_core_checker chk (.*);

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Stall the result side about 37 percent of the time, except in the steady phase.
  initial out_stall = 1'b0;
  always @(posedge clk)
    out_stall <= !steady_phase && ($urandom_range(99) < 37);

  // Abort a hung run.
  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Pick an operand: mostly small, sometimes an extreme, sometimes fully random.
  function automatic logic signed [31:0] pick_operand();
    case ($urandom_range(9))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return 32'(int'($urandom_range(4)) - 2);
      3, 4: return $urandom;
      default: return 32'(int'($urandom_range(32'h0004_0000)) - 32'sh0002_0000);
    endcase
  endfunction

  // Present one transaction and hold it while stalled; the task leaves valid high after acceptance.
  task automatic send_quat(input logic [2:0] op, input logic signed [31:0] v [9]);
    while (!steady_phase && $urandom_range(99) < 37) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_op <= op;
    {in_p_w, in_p_x, in_p_y, in_p_z} <= {v[0], v[1], v[2], v[3]};
    {in_q_w, in_q_x, in_q_y, in_q_z} <= {v[4], v[5], v[6], v[7]};
    in_factor <= v[8];
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  initial begin
    logic signed [31:0] v [9];
    logic signed [31:0] ext;
    int wait_cycles;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_op = '0;
    {in_p_w, in_p_x, in_p_y, in_p_z, in_q_w, in_q_x, in_q_y, in_q_z, in_factor} = '0;
    steady_phase = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: extremes on all opcodes, zero, full-scale and mixed norms, unit mul, rotate, scale.
    for (int op = 0; op < 8; op++) begin
      ext = (op % 2) ? 32'sh80000000 : 32'sh7fffffff;
      for (int i = 0; i < 9; i++) v[i] = ext;
      send_quat(3'(op), v);
    end
    for (int i = 0; i < 9; i++) v[i] = '0;
    send_quat(OP_NORM, v);
    for (int i = 0; i < 9; i++) v[i] = 32'sh80000000;
    send_quat(OP_NORM, v);
    v[0] = 32'sh0001_0000; v[1] = -32'sh0000_8000; v[2] = 32'sd1; v[3] = -32'sd1;
    send_quat(OP_NORM, v);
    for (int i = 0; i < 9; i++) v[i] = 32'sh0001_0000;
    send_quat(OP_MUL, v);
    send_quat(OP_ROT, v);
    v[8] = -32'sd1;
    send_quat(OP_SCALE, v);

    // Random: opcodes 0..4 mostly, with a steady stretch of back-to-back traffic.
    for (int n = 0; n < NUM_RANDOM; n++) begin
      steady_phase <= (n >= 600 && n < 800);
      for (int i = 0; i < 9; i++) v[i] = pick_operand();
      send_quat(($urandom_range(19) == 0) ? 3'($urandom_range(7, 5))
                                          : 3'($urandom_range(4)), v);
    end
    in_valid <= 1'b0;
    steady_phase <= 1'b0;

    while (pending_count != 0) @(posedge clk);
    wait_cycles = 0;
    while (wait_cycles < 100) begin
      @(posedge clk);
      wait_cycles++;
    end
    if (fail_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end
endmodule

>>> files.f
+incdir+rtl/core
rtl/core/qau_pkg.sv
rtl/core/qau_front.sv
rtl/core/qau_sqrt_cell.sv
rtl/core/qau_div_cell.sv
rtl/core/quaternion_arithmetic_unit_core.sv
dv/quaternion_arithmetic_unit_core_checker.sv
dv/quaternion_arithmetic_unit_core_test.sv
